@@ hw/rtl/slpc_pkg.sv @@
// slpc_pkg: shared types and constants of the status LED pattern controller
// no dependencies; imported by every module of the block

package slpc_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned PERIOD_W  = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME   = 2'd2;

   localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET = 16'd250;
   localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET = 16'd100;
   localparam logic [PERIOD_W-1:0] HOLD_TIME_RESET   = 16'd1500;

   // one poll
   typedef struct packed {
      logic              peer_connected;
      logic              storage_full;
      logic              link_up;
      logic              sync_active;
      logic [TIME_W-1:0] now_ms;
   } poll_type;

   // one result
   typedef struct packed {
      logic peer_led;
      logic user_led;
   } leds_type;

   // configuration register set
   typedef struct packed {
      logic [PERIOD_W-1:0] slow_period;
      logic [PERIOD_W-1:0] fast_period;
      logic [PERIOD_W-1:0] hold_time;
   } cfg_type;

endpackage

@@ hw/rtl/status_led_pattern_controller.sv @@
// status_led_pattern_controller: top level with the poll and result stream registers
// depends on slpc_pkg and slpc_engine
//
// Takes one poll beat per cycle while the result side keeps taking beats, and returns
// one result beat per poll, in order. A poll is captured in an input register, the LED
// pattern state is updated from it by combinational logic (three blink timers and the
// connect-hold compare), and the new LED levels land in an output register.
// Configuration writes take effect at the next edge and belong between polls.

module status_led_pattern_controller (
   input  logic                            clock,
   input  logic                            reset,
   // poll stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] now_ms, [32] sync_active, [33] link_up, [34] storage_full,
   // [35] peer_connected, [39:36] zero
   input  logic [slpc_pkg::REQ_DATA_W-1:0] req_tdata,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] user_led, [1] peer_led, [7:2] zero
   output logic [slpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration
   input  logic                            csr_we,
   input  logic [slpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slpc_pkg::PERIOD_W-1:0]   csr_wdata
);
   import slpc_pkg::*;

   logic     poll_valid_ff, poll_valid_in;
   poll_type poll_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   leds_type rsp_ff;
   leds_type leds_next;
   logic     advance;
   logic     req_beat;

   // poll moves on when the output register is empty or being drained
   assign advance    = poll_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~poll_valid_ff | advance;
   assign req_beat   = req_tvalid & req_tready;

   assign poll_valid_in = req_beat | (poll_valid_ff & ~advance);
   assign rsp_valid_in  = advance | (rsp_valid_ff & ~rsp_tready);

   slpc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (advance),
      .poll      (poll_ff),
      .leds_next (leds_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         poll_ff <= poll_type'(req_tdata[$bits(poll_type)-1:0]);
      end
      if (advance) begin
         rsp_ff <= leds_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(leds_type)){1'b0}}, rsp_ff};

endmodule

@@ hw/rtl/slpc_blink.sv @@
// slpc_blink: toggle check of one blink, (now - mark) mod 2^32 >= period
// depends on slpc_pkg

module slpc_blink (
   input  logic [slpc_pkg::TIME_W-1:0]   now_ms,
   input  logic [slpc_pkg::TIME_W-1:0]   mark,
   input  logic [slpc_pkg::PERIOD_W-1:0] period,
   output logic                          due
);
   import slpc_pkg::*;

   logic [TIME_W-1:0] elapsed;

   assign elapsed = now_ms - mark;
   assign due     = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period};

endmodule

@@ hw/rtl/slpc_engine.sv @@
// slpc_engine: pattern state, configuration registers and the per-poll update
// depends on slpc_pkg and slpc_blink

module slpc_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [slpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slpc_pkg::PERIOD_W-1:0]  csr_wdata,
   input  logic                           fire,
   input  slpc_pkg::poll_type             poll,
   output slpc_pkg::leds_type             leds_next
);
   import slpc_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              user_ff, user_in;
   logic              peer_ff, peer_in;
   logic [TIME_W-1:0] search_mark_ff, search_mark_in;
   logic              search_phase_ff, search_phase_in;
   logic [TIME_W-1:0] alarm_mark_ff, alarm_mark_in;
   logic              alarm_phase_ff, alarm_phase_in;
   logic [TIME_W-1:0] scan_mark_ff, scan_mark_in;
   logic              scan_phase_ff, scan_phase_in;
   logic              prior_ff, prior_in;
   logic              hold_active_ff, hold_active_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;

   logic              search_due, alarm_due, scan_due;
   logic              connect_edge;
   logic              hold_mid;
   logic [TIME_W-1:0] deadline_mid;
   logic [TIME_W-1:0] remaining;

   slpc_blink u_search (
      .now_ms (poll.now_ms),
      .mark   (search_mark_ff),
      .period (cfg_ff.slow_period),
      .due    (search_due)
   );

   slpc_blink u_alarm (
      .now_ms (poll.now_ms),
      .mark   (alarm_mark_ff),
      .period (cfg_ff.fast_period),
      .due    (alarm_due)
   );

   slpc_blink u_scan (
      .now_ms (poll.now_ms),
      .mark   (scan_mark_ff),
      .period (cfg_ff.slow_period),
      .due    (scan_due)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOW_PERIOD: cfg_in.slow_period = csr_wdata;
            CSR_FAST_PERIOD: cfg_in.fast_period = csr_wdata;
            CSR_HOLD_TIME:   cfg_in.hold_time   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // hold state as it stands after the connect edge of this poll
   assign connect_edge = poll.peer_connected & ~prior_ff;
   assign hold_mid     = poll.peer_connected & (connect_edge | hold_active_ff);
   assign deadline_mid = connect_edge
                         ? poll.now_ms + {{(TIME_W-PERIOD_W){1'b0}}, cfg_ff.hold_time}
                         : deadline_ff;
   assign remaining    = deadline_mid - poll.now_ms;

   always_comb begin
      user_in         = user_ff;
      peer_in         = peer_ff;
      search_mark_in  = search_mark_ff;
      search_phase_in = search_phase_ff;
      alarm_mark_in   = alarm_mark_ff;
      alarm_phase_in  = alarm_phase_ff;
      scan_mark_in    = scan_mark_ff;
      scan_phase_in   = scan_phase_ff;
      prior_in        = prior_ff;
      hold_active_in  = hold_active_ff;
      deadline_in     = deadline_ff;
      if (fire) begin
         if (poll.sync_active) begin
            peer_in = 1'b0;
            if (poll.link_up) begin
               user_in = 1'b1;
            end else if (search_due) begin
               search_mark_in  = poll.now_ms;
               search_phase_in = ~search_phase_ff;
               user_in         = ~search_phase_ff;
            end
         end else if (poll.storage_full) begin
            peer_in = 1'b0;
            if (alarm_due) begin
               alarm_mark_in  = poll.now_ms;
               alarm_phase_in = ~alarm_phase_ff;
               user_in        = ~alarm_phase_ff;
            end
         end else begin
            user_in     = 1'b0;
            prior_in    = poll.peer_connected;
            deadline_in = deadline_mid;
            if (!poll.peer_connected) begin
               hold_active_in = 1'b0;
               if (scan_due) begin
                  scan_mark_in  = poll.now_ms;
                  scan_phase_in = ~scan_phase_ff;
                  peer_in       = ~scan_phase_ff;
               end
            end else if (hold_mid && (remaining != '0) && !remaining[TIME_W-1]) begin
               // hold still live as a signed difference
               hold_active_in = 1'b1;
               peer_in        = 1'b1;
            end else begin
               hold_active_in = 1'b0;
               peer_in        = 1'b0;
            end
         end
      end
   end

   assign leds_next.user_led = user_in;
   assign leds_next.peer_led = peer_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_period <= SLOW_PERIOD_RESET;
         cfg_ff.fast_period <= FAST_PERIOD_RESET;
         cfg_ff.hold_time   <= HOLD_TIME_RESET;
         user_ff            <= 1'b0;
         peer_ff            <= 1'b0;
         search_mark_ff     <= '0;
         search_phase_ff    <= 1'b0;
         alarm_mark_ff      <= '0;
         alarm_phase_ff     <= 1'b0;
         scan_mark_ff       <= '0;
         scan_phase_ff      <= 1'b0;
         prior_ff           <= 1'b0;
         hold_active_ff     <= 1'b0;
         deadline_ff        <= '0;
      end else begin
         cfg_ff          <= cfg_in;
         user_ff         <= user_in;
         peer_ff         <= peer_in;
         search_mark_ff  <= search_mark_in;
         search_phase_ff <= search_phase_in;
         alarm_mark_ff   <= alarm_mark_in;
         alarm_phase_ff  <= alarm_phase_in;
         scan_mark_ff    <= scan_mark_in;
         scan_phase_ff   <= scan_phase_in;
         prior_ff        <= prior_in;
         hold_active_ff  <= hold_active_in;
         deadline_ff     <= deadline_in;
      end
   end

endmodule

@@ hw/rtl/slpc_checker.sv @@
// slpc_checker: port-level checks of the status LED pattern controller
// depends on slpc_pkg; bound to status_led_pattern_controller

module slpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [slpc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import slpc_pkg::*;

   // pipeline comes out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

   // with nothing waiting on the result side a poll is always taken
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("poll refused while result side empty");

   // pad bits of a result beat stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:2] == '0))
      else $error("result pad bits set");

endmodule

bind status_led_pattern_controller slpc_checker u_slpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/status_led_pattern_controller_tb.sv @@
// status_led_pattern_controller_tb: self-checking bench for the status LED controller
// keeps its own LED pattern model, streams polls with random gaps and checks every result beat
// depends on slpc_pkg and status_led_pattern_controller
`timescale 1ns / 1ps

module status_led_pattern_controller_tb;
   import slpc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int IDLE_PCT        = 23;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES   = 6;
   localparam int STALL_LIMIT     = 1000;
   localparam int SWEEP_POLLS     = 250;

   typedef struct packed {
      logic [TIME_W-1:0] mark;
      logic              phase;
   } blink_state_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [PERIOD_W-1:0]   csr_wdata;

   // LED pattern model
   logic [PERIOD_W-1:0] slow_ms, fast_ms, hold_ms;
   logic                usr_lit, peer_lit, last_connected, hold_on;
   logic [TIME_W-1:0]   hold_until;
   blink_state_type     search_blink, alarm_blink, scan_blink;

   leds_type expected_leds[$];
   int       mismatches;
   int       stall_cycles;
   bit       no_idle;
   bit       hold_off_pending;

   // random poll walk
   logic [TIME_W-1:0] walk_ms;
   bit walk_sync, walk_link, walk_full, walk_conn;

   status_led_pattern_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit blink_fires(input logic [TIME_W-1:0] now,
                                      input logic [PERIOD_W-1:0] period,
                                      inout blink_state_type b);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - b.mark;
      if (elapsed >= TIME_W'(period)) begin
         b.mark  = now;
         b.phase = ~b.phase;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic leds_type predict_leds(input poll_type p);
      leds_type          r;
      logic [TIME_W-1:0] left;
      if (p.sync_active) begin
         peer_lit = 1'b0;
         if (p.link_up)
            usr_lit = 1'b1;
         else if (blink_fires(p.now_ms, slow_ms, search_blink))
            usr_lit = search_blink.phase;
      end else if (p.storage_full) begin
         if (blink_fires(p.now_ms, fast_ms, alarm_blink))
            usr_lit = alarm_blink.phase;
         peer_lit = 1'b0;
      end else begin
         usr_lit = 1'b0;
         if (p.peer_connected && !last_connected) begin
            hold_on    = 1'b1;
            hold_until = p.now_ms + TIME_W'(hold_ms);
         end
         if (!p.peer_connected)
            hold_on = 1'b0;
         last_connected = p.peer_connected;
         if (!p.peer_connected) begin
            if (blink_fires(p.now_ms, slow_ms, scan_blink))
               peer_lit = scan_blink.phase;
         end else begin
            // hold is live while the signed distance to the deadline is positive
            left = hold_until - p.now_ms;
            if (hold_on && left != '0 && !left[TIME_W-1]) begin
               peer_lit = 1'b1;
            end else begin
               hold_on  = 1'b0;
               peer_lit = 1'b0;
            end
         end
      end
      r.user_led = usr_lit;
      r.peer_led = peer_lit;
      return r;
   endfunction

   function automatic poll_type make_poll(input logic [TIME_W-1:0] ms,
                                          input bit s, input bit l, input bit f, input bit c);
      poll_type p;
      p.now_ms         = ms;
      p.sync_active    = s;
      p.link_up        = l;
      p.storage_full   = f;
      p.peer_connected = c;
      return p;
   endfunction

   // mostly a forward walk of time with sticky status bits, now and then pure noise
   function automatic poll_type random_poll();
      poll_type          p;
      logic [TIME_W-1:0] scale;
      int unsigned       pick;
      scale = TIME_W'(slow_ms);
      if (TIME_W'(fast_ms) > scale) scale = TIME_W'(fast_ms);
      if (TIME_W'(hold_ms) > scale) scale = TIME_W'(hold_ms);
      if (scale < 4) scale = 4;
      if ($urandom_range(0, 23) == 0)
         return make_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 15);
      if (pick < 6)
         walk_ms = walk_ms + $urandom_range(0, 3);
      else if (pick < 13)
         walk_ms = walk_ms + $urandom_range(0, scale);
      else if (pick < 15)
         walk_ms = walk_ms + $urandom_range(scale, 2 * scale);
      else
         walk_ms = $urandom;
      if (walk_sync) walk_sync = ($urandom_range(0, 3) != 0);
      else           walk_sync = ($urandom_range(0, 19) == 0);
      if (walk_full) walk_full = ($urandom_range(0, 3) != 0);
      else           walk_full = ($urandom_range(0, 14) == 0);
      if ($urandom_range(0, 7) == 0) walk_link = ~walk_link;
      if ($urandom_range(0, 7) == 0) walk_conn = ~walk_conn;
      p = make_poll(walk_ms, walk_sync, walk_link, walk_full, walk_conn);
      return p;
   endfunction

   // valid stays high after a beat; a gap lowers it on its own falling edge
   task automatic send_poll(input poll_type p);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = REQ_DATA_W'(p);
      do @(posedge clock); while (!req_tready);
      expected_leds.push_back(predict_leds(p));
   endtask

   task automatic send_random(input int count);
      repeat (count) send_poll(random_poll());
   endtask

   task automatic stop_polls();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_results_done();
      while (expected_leds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_SLOW_PERIOD: slow_ms = value;
         CSR_FAST_PERIOD: fast_ms = value;
         CSR_HOLD_TIME:   hold_ms = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [PERIOD_W-1:0] slow, input logic [PERIOD_W-1:0] fast,
                             input logic [PERIOD_W-1:0] hold);
      stop_polls();
      wait_results_done();
      write_csr(CSR_SLOW_PERIOD, slow);
      write_csr(CSR_FAST_PERIOD, fast);
      write_csr(CSR_HOLD_TIME, hold);
   endtask

   task automatic test_directed_modes();
      send_poll(make_poll(32'd0,    1, 1, 0, 0)); // sync with link: solid
      send_poll(make_poll(32'd0,    1, 0, 0, 0));
      send_poll(make_poll(32'd249,  1, 0, 0, 0));
      send_poll(make_poll(32'd250,  1, 0, 0, 0)); // search blink toggles
      send_poll(make_poll(32'd500,  1, 0, 0, 0));
      send_poll(make_poll(32'd600,  0, 0, 1, 0)); // storage alarm
      send_poll(make_poll(32'd650,  0, 0, 1, 1));
      send_poll(make_poll(32'd700,  1, 1, 1, 1)); // sync beats storage full
      send_poll(make_poll(32'd800,  0, 0, 0, 0)); // peer scan
      send_poll(make_poll(32'd900,  0, 1, 0, 1)); // connect edge starts hold
      send_poll(make_poll(32'd2399, 0, 0, 0, 1));
      send_poll(make_poll(32'd2400, 0, 0, 0, 1)); // deadline reached
      send_poll(make_poll(32'd2500, 0, 0, 0, 1));
      send_poll(make_poll(32'd2600, 0, 0, 1, 0)); // full poll leaves connect history
      send_poll(make_poll(32'd2700, 0, 0, 0, 1)); // no new edge
      send_poll(make_poll(32'd2800, 0, 0, 0, 0));
      send_poll(make_poll(32'hFFFF_FF00, 0, 0, 0, 1)); // hold across the wrap
      send_poll(make_poll(32'h0000_0100, 0, 0, 0, 1));
      send_poll(make_poll(32'h0000_0600, 0, 0, 0, 1));
      send_poll(make_poll(32'hFFFF_FFFF, 1, 1, 1, 1));
      send_poll(make_poll(32'd0, 0, 0, 0, 0));
   endtask

   task automatic test_csr_corners();
      // zero periods toggle on every poll, zero hold gives no solid phase
      set_config(16'd0, 16'd0, 16'd0);
      write_csr(CSR_UNMAPPED, 16'hFFFF);
      send_poll(make_poll(32'd10, 1, 0, 0, 0));
      send_poll(make_poll(32'd10, 1, 0, 0, 0));
      send_poll(make_poll(32'd10, 0, 0, 1, 0));
      send_poll(make_poll(32'd10, 0, 0, 1, 0));
      send_poll(make_poll(32'd11, 0, 0, 0, 0));
      send_poll(make_poll(32'd11, 0, 0, 0, 1));
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_poll(make_poll(32'd11, 0, 0, 0, 0));
      send_poll(make_poll(32'd12, 0, 0, 0, 1));
      send_poll(make_poll(32'd65546, 0, 0, 0, 1));
      send_poll(make_poll(32'd65547, 0, 0, 0, 1));
   endtask

   task automatic test_setting_sweep();
      set_config(16'd1, 16'd1, 16'd0);
      send_random(SWEEP_POLLS);
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_random(SWEEP_POLLS);
      set_config(PERIOD_W'($urandom_range(1, 20)), PERIOD_W'($urandom_range(1, 20)),
                 PERIOD_W'($urandom_range(0, 40)));
      send_random(SWEEP_POLLS);
      set_config(PERIOD_W'($urandom_range(1, 65535)), PERIOD_W'($urandom_range(1, 65535)),
                 PERIOD_W'($urandom_range(0, 65535)));
      send_random(SWEEP_POLLS);
      set_config(SLOW_PERIOD_RESET, FAST_PERIOD_RESET, HOLD_TIME_RESET);
      send_random(SWEEP_POLLS);
   endtask

   // receiver stops long enough for the block to fill and push back on polls
   task automatic test_result_backpressure();
      hold_off_pending = 1'b1;
      send_random(60);
   endtask

   task automatic test_drain_pause();
      send_random(40);
      stop_polls();
      wait_results_done();
      send_random(40);
   endtask

   task automatic test_unbroken_stream();
      no_idle = 1'b1;
      send_random(200);
      stop_polls();
      wait_results_done();
      no_idle = 1'b0;
   endtask

   // result side ready, with random stalls and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // compare each result beat with the oldest predicted LED pair
   always @(posedge clock) begin
      leds_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = leds_type'(rsp_tdata[1:0]);
         if (expected_leds.size() == 0) begin
            $error("result beat with no poll pending: user_led %0b peer_led %0b",
                   got.user_led, got.peer_led);
            mismatches++;
         end else begin
            want = expected_leds.pop_front();
            if (got.user_led !== want.user_led) begin
               $error("user_led mismatch: expected %0b actual %0b", want.user_led, got.user_led);
               mismatches++;
            end
            if (got.peer_led !== want.peer_led) begin
               $error("peer_led mismatch: expected %0b actual %0b", want.peer_led, got.peer_led);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      mismatches       = 0;
      no_idle          = 1'b0;
      hold_off_pending = 1'b0;
      slow_ms          = SLOW_PERIOD_RESET;
      fast_ms          = FAST_PERIOD_RESET;
      hold_ms          = HOLD_TIME_RESET;
      usr_lit          = 1'b0;
      peer_lit         = 1'b0;
      last_connected   = 1'b0;
      hold_on          = 1'b0;
      hold_until       = '0;
      search_blink     = '0;
      alarm_blink      = '0;
      scan_blink       = '0;
      walk_ms          = '0;
      walk_sync        = 1'b0;
      walk_link        = 1'b0;
      walk_full        = 1'b0;
      walk_conn        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_modes();
      test_csr_corners();
      test_setting_sweep();
      test_result_backpressure();
      test_drain_pause();
      test_unbroken_stream();

      stop_polls();
      wait_results_done();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_leds.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
